// ===== rtl/core/battery_level_led_indicator_assert.svh =====
// Assertion macros used by the checker of the LED indicator.
`ifndef BATTERY_LEVEL_LED_INDICATOR_ASSERT_SVH
`define BATTERY_LEVEL_LED_INDICATOR_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define BLL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define BLL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also watches reset itself.
`define BLL_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bll_pkg.sv =====
package bll_pkg;

  localparam int FSC_W = 10;
  localparam int PHASE_W = 3;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [FSC_W-1:0] FSC_RESET = 10'd982;

  // thresholds are full_scale_code * U / 42
  localparam int FULL_SCALE_DIV = 42;
  localparam int LEVEL_U_W = 6;
  localparam int NUM_LEVELS = 5;
  localparam logic [LEVEL_U_W-1:0] LEVEL_U [NUM_LEVELS] = '{
    6'd33, 6'd36, 6'd38, 6'd39, 6'd41
  };

  localparam logic [PHASE_W-1:0] PHASE_RESET = 3'd1;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_FULL_SCALE = 1'b0;
  localparam reg_idx_t REG_IS_CAL = 1'b1;

  typedef struct packed {
    logic [FSC_W-1:0] full_scale_code;
    logic             is_calibrated;
  } cfg_t;

  typedef struct packed {
    logic green;
    logic yellow;
    logic red;
  } led_t;

endpackage

// ===== rtl/core/bll_cfg_regs.sv =====
module bll_cfg_regs import bll_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t             cfg_r;
  cfg_t             cfg_nxt;
  logic             wr_en;
  reg_idx_t         reg_idx;
  logic [FSC_W-1:0] fsc_masked;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // full-scale code keeps only as many bits as a sample has
  always_comb begin
    for (int i = 0; i < FSC_W; i++) begin
      fsc_masked[i] = (i < SAMPLE_BITS) ? pwdata[i] : 1'b0;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_FULL_SCALE: cfg_nxt.full_scale_code = fsc_masked;
        REG_IS_CAL:     cfg_nxt.is_calibrated = pwdata[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_scale_code <= FSC_RESET;
      cfg_r.is_calibrated   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FULL_SCALE: prdata = DATA_W'(cfg_r.full_scale_code);
      REG_IS_CAL:     prdata = DATA_W'(cfg_r.is_calibrated);
      default:        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/bll_led_decode.sv =====
module bll_led_decode import bll_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  cfg_t                   cfg,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [PHASE_W-1:0]     phase,
  output led_t                   led,
  output logic [PHASE_W-1:0]     phase_nxt
);

  localparam int MAG_W = (SAMPLE_BITS > FSC_W ? SAMPLE_BITS : FSC_W) + LEVEL_U_W;

  logic [MAG_W-1:0]      sample_scaled;
  logic [NUM_LEVELS-1:0] at_or_above;
  logic                  lit;

  // sample >= floor(fsc*U/42)  <=>  42*sample + 41 >= fsc*U, no divider needed
  assign sample_scaled = MAG_W'(sample) * MAG_W'(FULL_SCALE_DIV)
                       + MAG_W'(FULL_SCALE_DIV - 1);

  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      at_or_above[i] = sample_scaled >= (MAG_W'(cfg.full_scale_code) * MAG_W'(LEVEL_U[i]));
    end
  end

  assign lit = (phase != '0);

  always_comb begin
    led       = '0;
    phase_nxt = phase;
    if (!cfg.is_calibrated) begin
      // chase: green, yellow, red, off, off
      case (phase)
        3'd0: phase_nxt = PHASE_RESET;
        3'd1: begin
          led.green = 1'b1;
          phase_nxt = phase + 1'b1;
        end
        3'd2: begin
          led.yellow = 1'b1;
          phase_nxt  = phase + 1'b1;
        end
        3'd3: begin
          led.red   = 1'b1;
          phase_nxt = phase + 1'b1;
        end
        default: phase_nxt = '0;
      endcase
    end else if (at_or_above[4]) begin
      led.green = 1'b1;
      phase_nxt = PHASE_RESET;
    end else if (at_or_above[3]) begin
      led.green = lit;
      phase_nxt = PHASE_W'(!lit);
    end else if (at_or_above[2]) begin
      led.yellow = 1'b1;
      phase_nxt  = PHASE_RESET;
    end else if (at_or_above[1]) begin
      led.yellow = lit;
      phase_nxt  = PHASE_W'(!lit);
    end else if (at_or_above[0]) begin
      led.red   = 1'b1;
      phase_nxt = PHASE_RESET;
    end else begin
      led.red   = lit;
      phase_nxt = PHASE_W'(!lit);
    end
  end

endmodule

// ===== rtl/core/battery_level_led_indicator.sv =====
// An acting tick goes through the input register and then the result register to out_*.
// Throughput: one input word per cycle while in_stall is low; one result word per PRESCALE_LAST+1 inputs.
// The input register stalls only when it holds an acting tick and out_* is stalled.
// Reset (rst_n low, synchronous): pipeline empty, prescaler 0, phase 1,
// full_scale_code 982, is_calibrated 0.
module battery_level_led_indicator import bll_pkg::*; #(
  parameter int PRESCALE_LAST = 2,
  parameter int SAMPLE_BITS   = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // tick words
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_adc_sample,
  // LED words
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_green_on,
  output logic                   out_yellow_on,
  output logic                   out_red_on,
  // register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  localparam int DIV_W = (PRESCALE_LAST > 0) ? $clog2(PRESCALE_LAST + 1) : 1;

  cfg_t                   cfg;

  // input register
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic [SAMPLE_BITS-1:0] s1_sample_r;

  // block state
  logic [DIV_W-1:0]       div_r;
  logic [DIV_W-1:0]       div_nxt;
  logic [PHASE_W-1:0]     phase_r;
  logic [PHASE_W-1:0]     phase_nxt;
  logic [PHASE_W-1:0]     phase_calc;

  // result register
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  led_t                   out_led_r;
  led_t                   led_calc;

  logic                   acts;
  logic                   out_free;
  logic                   s1_fire;
  logic                   in_take;

  bll_cfg_regs #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  bll_led_decode #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_decode (
    .cfg      (cfg),
    .sample   (s1_sample_r),
    .phase    (phase_r),
    .led      (led_calc),
    .phase_nxt(phase_calc)
  );

  // Only every (PRESCALE_LAST+1)-th tick acts; the rest just bump the divider
  // and leave without a result, so they never wait on the output side.
  assign acts     = (div_r == DIV_W'(PRESCALE_LAST));
  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && (!acts || out_free);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // divider and phase move only when a tick leaves the input register
  always_comb begin
    div_nxt   = div_r;
    phase_nxt = phase_r;
    if (s1_fire) begin
      if (acts) begin
        div_nxt   = '0;
        phase_nxt = phase_calc;
      end else begin
        div_nxt = div_r + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && acts) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      div_r       <= '0;
      phase_r     <= PHASE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      div_r       <= div_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r <= in_adc_sample;
    end
    if (s1_fire && acts) begin
      out_led_r <= led_calc;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_green_on  = out_led_r.green;
  assign out_yellow_on = out_led_r.yellow;
  assign out_red_on    = out_led_r.red;

endmodule

// ===== rtl/core/bll_checker.sv =====
`include "battery_level_led_indicator_assert.svh"

module bll_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_green_on,
  input logic out_yellow_on,
  input logic out_red_on
);

  // a held LED word must not change under stall
  `BLL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({out_green_on, out_yellow_on, out_red_on}), "LED word changed while stalled")

  // every band and chase step lights at most one LED
  `BLL_ASSERT_NOW(a_one_led, out_valid, $countones({out_green_on, out_yellow_on, out_red_on}) <= 1, "more than one LED lit")

  // input side backs up only behind a stalled result
  `BLL_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with output free")

  // reset empties the result register
  `BLL_ASSERT_ALWAYS_NEXT(a_reset_empty, !rst_n, !out_valid, "result valid right after reset")

endmodule

bind battery_level_led_indicator bll_checker u_bll_checker (.*);
